FILE: sv/cicd_pkg.sv
// ---------------------------------------------------------------------------
// cicd_pkg
// Shared types and constants of the cloud-in-cell current deposit core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cicd_pkg;

   localparam int AccWidth  = 48;
   localparam int IncWidth  = 48;
   localparam int SumWidth  = ((AccWidth > IncWidth) ? AccWidth : IncWidth) + 1;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   localparam logic [31:0] QOne     = 32'h0001_0000;
   localparam logic [16:0] FracOne  = 17'h1_0000;
   localparam logic [2:0]  CornerLast = 3'd7;
   localparam logic [1:0]  AxisLast   = 2'd2;
   localparam logic [4:0]  IterLast   = 5'd31;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_ORIGIN_Z   = 3'd2,
      CSR_INV_SIZE_X = 3'd3,
      CSR_INV_SIZE_Y = 3'd4,
      CSR_INV_SIZE_Z = 3'd5,
      CSR_CHARGE     = 3'd6,
      CSR_LIGHT      = 3'd7
   } csr_addr_type;

   // One memory row holds rho, jx, jy, jz of a corner.
   typedef logic [3:0][AccWidth-1:0] row_type;

endpackage

`default_nettype wire

FILE: sv/cicd_ifs.sv
// ---------------------------------------------------------------------------
// cicd channel interfaces
// Valid/ready channels for particle beats and corner result beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cicd_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] mom_x;
   logic signed [31:0] mom_y;
   logic signed [31:0] mom_z;
   logic               species;
   logic               last;

   modport source (output valid, pos_x, pos_y, pos_z, mom_x, mom_y, mom_z, species, last,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, mom_x, mom_y, mom_z, species, last,
                   output ready);
endinterface

interface cicd_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         corner;
   logic signed [31:0] rho;
   logic signed [31:0] cur_x;
   logic signed [31:0] cur_y;
   logic signed [31:0] cur_z;
   logic               end_of_run;

   modport source (output valid, corner, rho, cur_x, cur_y, cur_z, end_of_run, input ready);
   modport sink   (input valid, corner, rho, cur_x, cur_y, cur_z, end_of_run, output ready);
endinterface

`default_nettype wire

FILE: sv/cicd_isqrt.sv
// ---------------------------------------------------------------------------
// cicd_isqrt
// Bit-pair integer square root of a 64-bit value, one result bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cicd_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   import cicd_pkg::*;

   logic [63:0] rem_ff;
   logic [63:0] res_ff;
   logic [63:0] probe_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [63:0] trial_in;
   logic        fits;

   assign trial_in = res_ff + probe_ff;
   assign fits     = rem_ff >= trial_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff   <= radicand;
            res_ff   <= '0;
            probe_ff <= 64'h4000_0000_0000_0000;
            cnt_ff   <= '0;
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            if (fits) begin
               rem_ff <= rem_ff - trial_in;
               res_ff <= (res_ff >> 1) + probe_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            probe_ff <= probe_ff >> 2;
            cnt_ff   <= cnt_ff + 5'd1;
            if (cnt_ff == IterLast) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

`default_nettype wire

FILE: sv/cicd_div.sv
// ---------------------------------------------------------------------------
// cicd_div
// Restoring divider, 64-bit dividend by 33-bit divisor, one quotient bit per
// cycle. The caller guarantees that the quotient fits in 32 bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cicd_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [32:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   import cicd_pkg::*;

   logic [32:0] rem_ff;
   logic [31:0] low_ff;
   logic [32:0] den_ff;
   logic [31:0] quo_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [33:0] shift_in;
   logic [33:0] diff_in;
   logic        fits;

   assign shift_in = {rem_ff, low_ff[31]};
   assign diff_in  = shift_in - {1'b0, den_ff};
   assign fits     = shift_in >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= {1'b0, dividend[63:32]};
            low_ff  <= dividend[31:0];
            den_ff  <= divisor;
            quo_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff_in[32:0] : shift_in[32:0];
            low_ff <= {low_ff[30:0], 1'b0};
            quo_ff <= {quo_ff[30:0], fits};
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == IterLast) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: sv/cic_current_deposit_core.sv
// ---------------------------------------------------------------------------
// cic_current_deposit_core
// Cloud-in-cell charge and current deposit into eight corner accumulators.
// ---------------------------------------------------------------------------
// Work after a particle is accepted: momentum squares and cell fractions, a square root,
// three divisions, one charge scaling step and a memory read-modify-write per corner.
// One particle is in work at a time, so a new particle is accepted only when idle.
// A last particle then yields 8 result beats, each of which output stalls can hold.
// Reset returns the configuration and the sequencer to their defaults and marks every
// corner row empty.
`timescale 1ns / 1ps
`default_nettype none

module cic_current_deposit_core (
   input  logic                                 clock,
   input  logic                                 reset,
   cicd_req_if.sink                             req_if,
   cicd_rsp_if.source                           rsp_if,
   input  logic                                 csr_we,
   input  logic [cicd_pkg::CsrAddrWidth-1:0]    csr_addr,
   input  logic [cicd_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import cicd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_USQ, ST_SQGO, ST_SQWAIT, ST_DMUL, ST_DGO, ST_DWAIT, ST_BASE,
      ST_W1, ST_W2, ST_INC, ST_ACC, ST_ERD, ST_ELD, ST_EOUT
   } state_type;

   // Configuration.
   logic signed [31:0] origin_ff [3];
   logic [31:0]        inv_ff    [3];
   logic signed [31:0] charge_ff;
   logic [31:0]        light_ff;

   // Captured particle.
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] mom_ff [3];
   logic               species_ff;
   logic               last_ff;

   // Control.
   state_type  state_ff;
   logic [1:0] ax_ff;
   logic [2:0] corner_ff;
   logic [7:0] rowv_ff;

   // Datapath.
   logic [63:0]                sum_ff;
   logic [16:0]                frac_ff [3];
   logic [31:0]                gamma_ff;
   logic [63:0]                num_ff;
   logic [31:0]                vel_ff [3];
   logic [45:0]                base_mag_ff [4];
   logic [3:0]                 base_neg_ff;
   logic [16:0]                wxy_ff;
   logic [16:0]                w_ff;
   logic signed [IncWidth-1:0] inc_ff [4];
   row_type                    mem_rd_ff;
   logic signed [31:0]         out_ff [4];

   row_type mem [8];

   logic signed [31:0]         mom_sel;
   logic [31:0]                mom_mag;
   logic [63:0]                sum_in;
   logic signed [32:0]         diff;
   logic [63:0]                fprod;
   logic [16:0]                frac_in;
   logic [63:0]                num_in;
   logic [16:0]                wx, wy, wz;
   logic [33:0]                wxy_prod;
   logic [33:0]                w_prod;
   logic [31:0]                q_mag;
   logic                       q_neg;
   logic [31:0]                comp_mag [4];
   logic [3:0]                 comp_neg;
   logic [63:0]                bprod [4];
   logic [45:0]                base_mag_in [4];
   logic [62:0]                iprod [4];
   logic signed [IncWidth-1:0] inc_in [4];
   logic signed [SumWidth-1:0] acc_sum [4];
   row_type                    row_in;
   logic signed [AccWidth-1:0] acc_old [4];
   logic signed [31:0]         out_in [4];

   logic        sqrt_done;
   logic [31:0] sqrt_root;
   logic        div_done;
   logic [31:0] div_quo;

   localparam logic signed [SumWidth-1:0] AccMax =
      {{(SumWidth-AccWidth+1){1'b0}}, {(AccWidth-1){1'b1}}};
   localparam logic signed [SumWidth-1:0] AccMin = ~AccMax;
   localparam logic signed [AccWidth-1:0] OutMax =
      {{(AccWidth-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [AccWidth-1:0] OutMin = ~OutMax;

   // ---------------- configuration port ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= '0;
         inv_ff[0]    <= QOne;
         inv_ff[1]    <= QOne;
         inv_ff[2]    <= QOne;
         charge_ff    <= QOne;
         light_ff     <= QOne;
      end else if (csr_we) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_ORIGIN_X:   origin_ff[0] <= csr_wdata;
            CSR_ORIGIN_Y:   origin_ff[1] <= csr_wdata;
            CSR_ORIGIN_Z:   origin_ff[2] <= csr_wdata;
            CSR_INV_SIZE_X: inv_ff[0]    <= csr_wdata;
            CSR_INV_SIZE_Y: inv_ff[1]    <= csr_wdata;
            CSR_INV_SIZE_Z: inv_ff[2]    <= csr_wdata;
            CSR_CHARGE:     charge_ff    <= csr_wdata;
            CSR_LIGHT:      light_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- datapath logic ----------------
   always_comb begin
      mom_sel = mom_ff[ax_ff];
      mom_mag = mom_sel[31] ? 32'(-mom_sel) : mom_sel;
      sum_in  = sum_ff + 64'(mom_mag) * 64'(mom_mag);
      num_in  = 64'(mom_mag) * 64'(light_ff);

      // Fraction of the cell, clamped to [0, 1.0].
      diff  = {pos_ff[ax_ff][31], pos_ff[ax_ff]} - {origin_ff[ax_ff][31], origin_ff[ax_ff]};
      fprod = 64'(diff[31:0]) * 64'(inv_ff[ax_ff]);
      if (diff[32] || diff == '0) begin
         frac_in = '0;
      end else if (fprod[63:16] > 48'(FracOne)) begin
         frac_in = FracOne;
      end else begin
         frac_in = fprod[32:16];
      end

      wx = corner_ff[2] ? frac_ff[0] : FracOne - frac_ff[0];
      wy = corner_ff[1] ? frac_ff[1] : FracOne - frac_ff[1];
      wz = corner_ff[0] ? frac_ff[2] : FracOne - frac_ff[2];
      wxy_prod = 34'(wx) * 34'(wy);
      w_prod   = 34'(wxy_ff) * 34'(wz);

      // A positron flips the sign of the charge density.
      q_mag = charge_ff[31] ? 32'(-charge_ff) : charge_ff;
      q_neg = charge_ff[31] ^ species_ff;
      comp_mag[0] = QOne;
      comp_neg[0] = 1'b0;
      for (int k = 1; k < 4; k++) begin
         comp_mag[k] = vel_ff[k-1];
         comp_neg[k] = mom_ff[k-1][31];
      end
      for (int k = 0; k < 4; k++) begin
         bprod[k]       = 64'(comp_mag[k]) * 64'(q_mag);
         base_mag_in[k] = bprod[k][61:16];
         iprod[k]       = 63'(base_mag_ff[k]) * 63'(w_ff);
         inc_in[k]      = base_neg_ff[k] ? -IncWidth'(iprod[k][62:16])
                                         :  IncWidth'(iprod[k][62:16]);
         acc_old[k]     = rowv_ff[corner_ff] ? $signed(mem_rd_ff[k]) : '0;
         acc_sum[k]     = SumWidth'(acc_old[k]) + SumWidth'(inc_ff[k]);
         if (acc_sum[k] > AccMax) begin
            row_in[k] = AccMax[AccWidth-1:0];
         end else if (acc_sum[k] < AccMin) begin
            row_in[k] = AccMin[AccWidth-1:0];
         end else begin
            row_in[k] = acc_sum[k][AccWidth-1:0];
         end
         if (acc_old[k] > OutMax) begin
            out_in[k] = OutMax[31:0];
         end else if (acc_old[k] < OutMin) begin
            out_in[k] = OutMin[31:0];
         end else begin
            out_in[k] = acc_old[k][31:0];
         end
      end
   end

   cicd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_SQGO),
      .radicand (sum_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   cicd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_DGO),
      .dividend (num_ff),
      .divisor  ({gamma_ff, 1'b0}),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ---------------- accumulator memory ----------------
   always_ff @(posedge clock) begin
      if (state_ff == ST_ACC) begin
         mem[corner_ff] <= row_in;
      end
      if (state_ff == ST_W1 || state_ff == ST_ERD) begin
         mem_rd_ff <= mem[corner_ff];
      end
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ax_ff     <= '0;
         corner_ff <= '0;
         rowv_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  pos_ff[0]  <= req_if.pos_x;
                  pos_ff[1]  <= req_if.pos_y;
                  pos_ff[2]  <= req_if.pos_z;
                  mom_ff[0]  <= req_if.mom_x;
                  mom_ff[1]  <= req_if.mom_y;
                  mom_ff[2]  <= req_if.mom_z;
                  species_ff <= req_if.species;
                  last_ff    <= req_if.last;
                  sum_ff     <= 64'h1_0000_0000;
                  ax_ff      <= '0;
                  state_ff   <= ST_USQ;
               end
            end
            ST_USQ: begin
               sum_ff         <= sum_in;
               frac_ff[ax_ff] <= frac_in;
               if (ax_ff == AxisLast) begin
                  state_ff <= ST_SQGO;
               end else begin
                  ax_ff <= ax_ff + 2'd1;
               end
            end
            ST_SQGO: state_ff <= ST_SQWAIT;
            ST_SQWAIT: begin
               if (sqrt_done) begin
                  gamma_ff <= sqrt_root;
                  ax_ff    <= '0;
                  state_ff <= ST_DMUL;
               end
            end
            ST_DMUL: begin
               num_ff   <= num_in;
               state_ff <= ST_DGO;
            end
            ST_DGO: state_ff <= ST_DWAIT;
            ST_DWAIT: begin
               if (div_done) begin
                  vel_ff[ax_ff] <= div_quo;
                  if (ax_ff == AxisLast) begin
                     state_ff <= ST_BASE;
                  end else begin
                     ax_ff    <= ax_ff + 2'd1;
                     state_ff <= ST_DMUL;
                  end
               end
            end
            ST_BASE: begin
               for (int k = 0; k < 4; k++) begin
                  base_mag_ff[k] <= base_mag_in[k];
               end
               base_neg_ff <= comp_neg ^ {4{q_neg}};
               corner_ff   <= '0;
               state_ff    <= ST_W1;
            end
            ST_W1: begin
               wxy_ff   <= wxy_prod[32:16];
               state_ff <= ST_W2;
            end
            ST_W2: begin
               w_ff     <= w_prod[32:16];
               state_ff <= ST_INC;
            end
            ST_INC: begin
               for (int k = 0; k < 4; k++) begin
                  inc_ff[k] <= inc_in[k];
               end
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               rowv_ff[corner_ff] <= 1'b1;
               corner_ff          <= corner_ff + 3'd1;
               if (corner_ff == CornerLast) begin
                  state_ff <= last_ff ? ST_ERD : ST_IDLE;
               end else begin
                  state_ff <= ST_W1;
               end
            end
            ST_ERD: state_ff <= ST_ELD;
            ST_ELD: begin
               for (int k = 0; k < 4; k++) begin
                  out_ff[k] <= out_in[k];
               end
               // Dropping the valid bit clears the row.
               rowv_ff[corner_ff] <= 1'b0;
               state_ff           <= ST_EOUT;
            end
            ST_EOUT: begin
               if (rsp_if.ready) begin
                  corner_ff <= corner_ff + 3'd1;
                  state_ff  <= (corner_ff == CornerLast) ? ST_IDLE : ST_ERD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_if.ready      = state_ff == ST_IDLE;
   assign rsp_if.valid      = state_ff == ST_EOUT;
   assign rsp_if.corner     = corner_ff;
   assign rsp_if.rho        = out_ff[0];
   assign rsp_if.cur_x      = out_ff[1];
   assign rsp_if.cur_y      = out_ff[2];
   assign rsp_if.cur_z      = out_ff[3];
   assign rsp_if.end_of_run = corner_ff == CornerLast;

   // ---------------- assertions ----------------
   a_run_clears_rows: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && rsp_if.end_of_run) |=> (rowv_ff == '0))
      else $error("corner rows still marked after the last beat of a run");

   a_sqrt_in_wait: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == ST_SQWAIT))
      else $error("square root finished outside its wait state");

   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DWAIT))
      else $error("division finished outside its wait state");

   a_row_marked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |=> rowv_ff[$past(corner_ff)])
      else $error("accumulated row not marked valid");

endmodule

`default_nettype wire
